// File: hw/rtl/mrsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the request decoder.
// No dependencies; every other file in hw/rtl imports this package.
package mrsd_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  function_code;
		logic [15:0] reg_address;
		logic [15:0] write_value;
		logic [15:0] reg_count;
		logic [1:0]  exception_code;
		logic        reply_expected;
		logic [7:0]  error_count;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic zero;
	} crc_stat_t;

	typedef logic [4:0][31:0] range_set_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] ACT_READ     = 2'd0;
	localparam logic [1:0] ACT_WRITE    = 2'd1;
	localparam logic [1:0] ACT_EXC      = 2'd2;
	localparam logic [1:0] ACT_OVERFLOW = 2'd3;

	localparam logic [1:0] EXC_NONE     = 2'd0;
	localparam logic [1:0] EXC_FUNCTION = 2'd1;
	localparam logic [1:0] EXC_ADDRESS  = 2'd2;
	localparam logic [1:0] EXC_VALUE    = 2'd3;

	localparam logic [2:0] CFG_SLAVE_ADDRESS = 3'd0;
	localparam logic [2:0] CFG_TIMEOUT       = 3'd1;
	localparam logic [2:0] CFG_RANGE_A       = 3'd2;
	localparam logic [2:0] CFG_RANGE_B       = 3'd3;
	localparam logic [2:0] CFG_RANGE_C       = 3'd4;
	localparam logic [2:0] CFG_RANGE_D       = 3'd5;
	localparam logic [2:0] CFG_RANGE_E       = 3'd6;
	localparam logic [2:0] CFG_READ_MANY     = 3'd7;

	localparam logic [7:0]  FC_READ_HOLDING = 8'd3;
	localparam logic [7:0]  FC_WRITE_SINGLE = 8'd6;
	localparam logic [7:0]  FC_WRITE_COILS  = 8'd15;
	localparam logic [7:0]  FC_WRITE_MULTI  = 8'd16;
	localparam logic [7:0]  BROADCAST_ID    = 8'd0;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] MAX_REGS        = 16'd32;

	// An address is legal if any of the five inclusive ranges holds it.
	function automatic logic addr_ok(input logic [15:0] a, input range_set_t r);
		logic ok;
		ok = 1'b0;
		for (int i = 0; i < 5; i++) begin
			if (a >= r[i][15:0] && a <= r[i][31:16]) begin
				ok = 1'b1;
			end
		end
		return ok;
	endfunction

endpackage

// File: hw/rtl/modbus_rtu_slave_request_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the RTU slave request decoder: sequencer, config registers,
// output register. Depends on mrsd_pkg, mrsd_crc_unit, mrsd_frame_store.
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-----------------------
// in      | into      | in_valid / in_stall  | in_item  (in_item_t)
// out     | out of    | out_valid / out_stall| out_item (out_item_t)
// cfg     | into      | cfg_we               | cfg_index, cfg_data
//
// A tick leaves the sequencer idle. A byte passes through the transfer, eight
// steps of the bit-serial CRC unit and a check that it has finished; a byte that
// completes a frame then takes a decision step, address span checks (one address
// per check) and an emit per read result, or two frame store reads and an emit
// per write result. An overflowing byte goes straight to the output state.
// Reset clears the fill count, idle timer, error count and config to defaults;
// the frame store itself is not cleared. A stalled output holds the sequencer.
module modbus_rtu_slave_request_decoder_unit
	import mrsd_pkg::*;
#(
	parameter int FRAME_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int FILL_W = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W  = $clog2(FRAME_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_CRC, S_DECIDE, S_SPAN, S_EMIT_RD,
		S_RD_HI, S_RD_LO, S_EMIT_WR, S_OUT
	} state_t;

	state_t      state_q;
	logic [7:0]  slave_q;
	logic [15:0] timeout_q;
	range_set_t  ranges_q;
	logic        read_many_q;

	logic [FILL_W-1:0] fill_q;
	logic [15:0]       idle_q;
	logic [7:0]        errors_q;
	logic [7:0]        hdr_q [7];
	logic [4:0]        idx_q;
	logic              reply_q;
	logic              wr_mode_q;
	logic [7:0]        hi_q;
	out_item_t         res_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              in_xfer;
	logic              byte_xfer;
	logic              out_free;
	logic              out_load;
	logic [FILL_W-1:0] eff_fill;
	logic              store_byte;
	logic              complete;
	logic [7:0]        fc;
	logic [15:0]       addr;
	logic [15:0]       cnt;
	logic [15:0]       span_addr;
	logic              idx_last;
	logic [17:0]       read_bytes;
	logic [16:0]       twice_cnt;
	logic [7:0]        rd_pos;
	logic              mem_re;
	logic [7:0]        mem_rdata;
	crc_stat_t         crc_stat;
	logic [7:0]        err_next;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		in_xfer    = in_valid && !in_stall;
		byte_xfer  = in_xfer && (in_item.kind == KIND_BYTE);
		out_free   = !out_valid_q || !out_stall;
		// Load the output register from any of the emitting states.
		out_load   = out_free && (state_q == S_EMIT_RD || state_q == S_EMIT_WR ||
			state_q == S_OUT);
		// Drop a partial frame once the line has been quiet too long.
		eff_fill   = (idle_q > timeout_q) ? '0 : fill_q;
		store_byte = byte_xfer && (eff_fill < FILL_W'(FRAME_BYTES));
		fc         = hdr_q[1];
		addr       = {hdr_q[2], hdr_q[3]};
		cnt        = {hdr_q[4], hdr_q[5]};
		span_addr  = addr + {11'd0, idx_q};
		idx_last   = ({11'd0, idx_q} == (cnt - 16'd1));
		read_bytes = {1'b0, cnt, 1'b0} + 18'd5;
		twice_cnt  = {cnt, 1'b0};
		err_next   = errors_q + 8'd1;
		rd_pos     = 8'd7 + {2'b00, idx_q, 1'b0} + ((state_q == S_RD_LO) ? 8'd1 : 8'd0);
		mem_re     = (state_q == S_RD_HI) || (state_q == S_RD_LO);
		// Frame length by function code: fixed eight, or nine plus byte count.
		complete = 1'b0;
		if (fill_q >= FILL_W'(2)) begin
			if (fc >= 8'd1 && fc <= FC_WRITE_SINGLE) begin
				complete = (fill_q >= FILL_W'(8));
			end else if (fc == FC_WRITE_COILS || fc == FC_WRITE_MULTI) begin
				complete = (fill_q >= FILL_W'(7)) &&
					(10'(fill_q) >= 10'd9 + {2'b00, hdr_q[6]});
			end
		end
	end

	mrsd_crc_unit u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (store_byte),
		.init      (eff_fill == '0),
		.data_byte (in_item.data_byte),
		.stat      (crc_stat)
	);

	mrsd_frame_store #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (store_byte),
		.waddr (eff_fill[IDX_W-1:0]),
		.wdata (in_item.data_byte),
		.re    (mem_re),
		.raddr (rd_pos[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slave_q     <= 8'd1;
			timeout_q   <= 16'd10;
			ranges_q    <= '0;
			read_many_q <= 1'b0;
			fill_q      <= '0;
			idle_q      <= '0;
			errors_q    <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
			res_q       <= '0;
			hi_q        <= '0;
			hdr_q       <= '{default: '0};
			idx_q       <= '0;
			reply_q     <= 1'b0;
			wr_mode_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SLAVE_ADDRESS: slave_q <= cfg_data[7:0];
					CFG_TIMEOUT:       timeout_q <= cfg_data[15:0];
					CFG_RANGE_A:       ranges_q[0] <= cfg_data;
					CFG_RANGE_B:       ranges_q[1] <= cfg_data;
					CFG_RANGE_C:       ranges_q[2] <= cfg_data;
					CFG_RANGE_D:       ranges_q[3] <= cfg_data;
					CFG_RANGE_E:       ranges_q[4] <= cfg_data;
					CFG_READ_MANY:     read_many_q <= cfg_data[0];
					default: ;
				endcase
			end

			// Raise valid on a load, drop it once the transfer is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && in_item.kind == KIND_TICK) begin
						if (idle_q != 16'hFFFF) begin
							idle_q <= idle_q + 16'd1;
						end
					end else if (byte_xfer) begin
						idle_q <= '0;
						if (!store_byte) begin
							// Store full: drop the byte and report the overflow.
							fill_q   <= '0;
							errors_q <= err_next;
							res_q    <= '{ACT_OVERFLOW, 8'd0, 16'd0, 16'd0, 16'd0,
								EXC_NONE, 1'b0, err_next, 1'b1};
							state_q  <= S_OUT;
						end else begin
							fill_q <= eff_fill + FILL_W'(1);
							if (eff_fill < FILL_W'(7)) begin
								hdr_q[eff_fill[2:0]] <= in_item.data_byte;
							end
							state_q <= S_CRC;
						end
					end
				end
				S_CRC: begin
					if (!crc_stat.busy) begin
						state_q <= S_IDLE;
						if (complete) begin
							fill_q <= '0;
							if ((hdr_q[0] == slave_q || hdr_q[0] == BROADCAST_ID) &&
								crc_stat.zero) begin
								reply_q <= (hdr_q[0] != BROADCAST_ID);
								state_q <= S_DECIDE;
							end
						end
					end
				end
				S_DECIDE: begin
					idx_q   <= '0;
					state_q <= S_OUT;
					if (fc == FC_READ_HOLDING && reply_q) begin
						if (!addr_ok(addr, ranges_q)) begin
							errors_q <= err_next;
							res_q <= '{ACT_EXC, fc, addr, 16'd0, cnt, EXC_ADDRESS,
								reply_q, err_next, 1'b1};
						end else if (!read_many_q) begin
							if (cnt != 16'd1) begin
								errors_q <= err_next;
								res_q <= '{ACT_EXC, fc, addr, 16'd0, cnt, EXC_VALUE,
									reply_q, err_next, 1'b1};
							end else begin
								res_q <= '{ACT_READ, fc, addr, 16'd0, cnt, EXC_NONE,
									reply_q, errors_q, 1'b1};
							end
						end else if (cnt == 16'd0 || cnt > MAX_REGS ||
							read_bytes > 18'(FRAME_BYTES)) begin
							errors_q <= err_next;
							res_q <= '{ACT_EXC, fc, addr, 16'd0, cnt, EXC_VALUE,
								reply_q, err_next, 1'b1};
						end else begin
							wr_mode_q <= 1'b0;
							state_q   <= S_SPAN;
						end
					end else if (fc == FC_WRITE_SINGLE) begin
						if (!addr_ok(addr, ranges_q)) begin
							errors_q <= err_next;
							res_q <= '{ACT_EXC, fc, addr, 16'd0, 16'd1, EXC_ADDRESS,
								reply_q, err_next, 1'b1};
						end else begin
							res_q <= '{ACT_WRITE, fc, addr, cnt, 16'd1, EXC_NONE,
								reply_q, errors_q, 1'b1};
						end
					end else if (fc == FC_WRITE_MULTI) begin
						if (cnt == 16'd0 || cnt > MAX_REGS ||
							{9'd0, hdr_q[6]} != twice_cnt) begin
							errors_q <= err_next;
							res_q <= '{ACT_EXC, fc, addr, 16'd0, cnt, EXC_VALUE,
								reply_q, err_next, 1'b1};
						end else begin
							wr_mode_q <= 1'b1;
							state_q   <= S_SPAN;
						end
					end else begin
						// Unsupported code, or a broadcast read.
						errors_q <= err_next;
						res_q <= '{ACT_EXC, fc, 16'd0, 16'd0, 16'd0, EXC_FUNCTION,
							reply_q, err_next, 1'b1};
					end
				end
				S_SPAN: begin
					// Check one address of the span per cycle.
					if (!addr_ok(span_addr, ranges_q)) begin
						errors_q <= err_next;
						res_q <= '{ACT_EXC, fc, addr, 16'd0, cnt, EXC_ADDRESS,
							reply_q, err_next, 1'b1};
						state_q <= S_OUT;
					end else if (idx_last) begin
						idx_q   <= '0;
						state_q <= wr_mode_q ? S_RD_HI : S_EMIT_RD;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				S_EMIT_RD: begin
					if (out_free) begin
						out_item_q  <= '{ACT_READ, fc, span_addr, 16'd0, cnt, EXC_NONE,
							reply_q, errors_q, idx_last};
						idx_q       <= idx_q + 5'd1;
						if (idx_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RD_HI: begin
					state_q <= S_RD_LO;
				end
				S_RD_LO: begin
					hi_q    <= mem_rdata;
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_free) begin
						out_item_q  <= '{ACT_WRITE, fc, span_addr, {hi_q, mem_rdata}, cnt,
							EXC_NONE, reply_q, errors_q, idx_last};
						idx_q       <= idx_q + 5'd1;
						state_q     <= idx_last ? S_IDLE : S_RD_HI;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_item_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/mrsd_crc_unit.sv
`timescale 1ns / 1ps
// Bit-serial CRC-16 unit, one polynomial step per cycle, eight per byte.
// Depends on mrsd_pkg.
module mrsd_crc_unit
	import mrsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       init,
	input  logic [7:0] data_byte,
	output crc_stat_t  stat
);

	logic [15:0] crc_q;
	logic [3:0]  steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			steps_q <= 4'd0;
		end else if (start) begin
			crc_q   <= (init ? CRC_INIT : crc_q) ^ {8'h00, data_byte};
			steps_q <= 4'd8;
		end else if (steps_q != 4'd0) begin
			crc_q   <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			steps_q <= steps_q - 4'd1;
		end
	end

	// Residue over frame plus its own CRC is zero when the CRC matches.
	assign stat.busy = (steps_q != 4'd0);
	assign stat.zero = (crc_q == 16'h0000);

endmodule

// File: hw/rtl/mrsd_frame_store.sv
`timescale 1ns / 1ps
// Frame byte memory: one write port, one registered read port.
// Depends on mrsd_pkg for house conventions only.
module mrsd_frame_store
	import mrsd_pkg::*;
#(
	parameter int FRAME_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(FRAME_BYTES)-1:0] waddr,
	input  logic [7:0]                     wdata,
	input  logic                           re,
	input  logic [$clog2(FRAME_BYTES)-1:0] raddr,
	output logic [7:0]                     rdata
);

	logic [7:0] mem_q [FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/mrsd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the request decoder, bound to the top level.
// Depends on mrsd_pkg and modbus_rtu_slave_request_decoder_unit.
module mrsd_checker
	import mrsd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input in_item_t   in_item,
	input logic       out_valid,
	input logic       out_stall,
	input out_item_t  out_item
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// An accepted byte, stored or dropped, keeps the sequencer busy for at least the next cycle.
	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.kind == KIND_BYTE |=> in_stall)
		else $error("byte transfer did not occupy the sequencer");

	// A tick leaves the sequencer free to accept in the next cycle.
	a_tick_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.kind == KIND_TICK |=> !in_stall)
		else $error("tick transfer left the sequencer busy");

	// Only exceptions carry an exception code, and always a nonzero one.
	a_exc_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_item.action == ACT_EXC) == (out_item.exception_code != EXC_NONE)))
		else $error("exception code does not match action");

endmodule

bind modbus_rtu_slave_request_decoder_unit mrsd_checker u_mrsd_checker (.*);
